[hw/rtl/mtes_pkg.sv]
// shared types and constants of the multi timer expiry scheduler
// depends on nothing; used by the alu, the unit, the checker and the testbench
package mtes_pkg;

  // field widths fixed by the word format
  localparam int SLOT_W = 4;
  localparam int MS_W   = 32;
  localparam int TIME_W = 48;
  localparam int DL_W   = 49;

  // input and output word widths
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;

  // timeout codes
  localparam logic [MS_W-1:0] TMO_MAX  = 32'h7FFF_FFFF;
  localparam logic [MS_W-1:0] TMO_NONE = 32'hFFFF_FFFF;
  localparam logic [MS_W-1:0] TMO_DUE  = 32'h0000_0000;

  // word kinds on the output
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNARMED = 1'b1;

  // operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_RESET = 2'd2,
    OP_ADV   = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_EXEC     = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_CHECK    = 7'b0001000,
    ST_TMO      = 7'b0010000,
    ST_FIRE_RD  = 7'b0100000,
    ST_FIRE_UPD = 7'b1000000
  } state_e;

endpackage

[hw/rtl/mtes_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module mtes_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/mtes_alu.sv]
// shared 49-bit add / subtract unit with borrow out
// depends on mtes_pkg for the deadline width
module mtes_alu (
  input  logic [mtes_pkg::DL_W-1:0] a_i,
  input  logic [mtes_pkg::DL_W-1:0] b_i,
  input  logic                      sub_i,
  output logic [mtes_pkg::DL_W-1:0] res_o,
  output logic                      borrow_o
);

  logic [mtes_pkg::DL_W-1:0] b_op;
  logic [mtes_pkg::DL_W:0]   sum;

  // a + b, or a + ~b + 1 for a - b
  assign b_op     = sub_i ? ~b_i : b_i;
  assign sum      = {1'b0, a_i} + {1'b0, b_op} + {{mtes_pkg::DL_W{1'b0}}, sub_i};
  assign res_o    = sum[mtes_pkg::DL_W-1:0];
  assign borrow_o = sub_i & ~sum[mtes_pkg::DL_W];

endmodule

[hw/rtl/multi_timer_expiry_scheduler_unit.sv]
// Sequence: start, stop and reset load the final word after one full slot scan through the
// deadline ram and the shared 49-bit add/subtract unit and the due check, with a timeout step
// when a timeout has to be computed; an advance adds, for each slot that expires, the period
// fetch, the report with reload or disarm, and a full rescan.
// Throughput: one operation at a time; the next word is taken once the sequencer is idle.
// Reset: rst_ni clears the time, all armed flags and the sequencer; ram contents need none.
module multi_timer_expiry_scheduler_unit #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // op[1:0], slot[5:2], delay_ms[37:6], period_ms[69:38], now_ms[117:70], zero pad
  input  logic [mtes_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fired_slot[3:0], status[4], next_timeout[36:5], zero pad
  output logic [mtes_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind[0]
  output logic [0:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int DW = mtes_pkg::DL_W;

  mtes_pkg::state_e state_q, state_d;

  // latched input word
  mtes_pkg::op_e                  op_q;
  logic [mtes_pkg::SLOT_W-1:0]    slot_q;
  logic [mtes_pkg::MS_W-1:0]      delay_q;
  logic [mtes_pkg::MS_W-1:0]      period_q;
  logic [mtes_pkg::TIME_W-1:0]    now_q;

  // timer state
  logic [mtes_pkg::TIME_W-1:0]    cur_q, cur_d;
  logic [NUM_TIMERS-1:0]          armed_q, armed_d;
  logic                           status_q, status_d;

  // scan state
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]                  cmp_idx_q, cmp_idx_d;
  logic                           best_vld_q, best_vld_d;
  logic [IW-1:0]                  best_idx_q, best_idx_d;
  logic [DW-1:0]                  best_dl_q, best_dl_d;

  // output register
  logic                           out_vld_q;
  logic                           kind_q, status_out_q, last_q;
  logic [mtes_pkg::SLOT_W-1:0]    fired_q;
  logic [mtes_pkg::MS_W-1:0]      tmo_q;
  logic                           ld_out, ld_kind, ld_status;
  logic [mtes_pkg::SLOT_W-1:0]    ld_fired;
  logic [mtes_pkg::MS_W-1:0]      ld_tmo;
  logic                           out_free;

  // shared unit and ram ports
  logic [DW-1:0]                  alu_a, alu_b, alu_res;
  logic                           alu_sub, alu_borrow;
  logic                           dl_we, pr_we;
  logic [IW-1:0]                  dl_waddr, rd_addr;
  logic [DW-1:0]                  dl_rdata;
  logic [mtes_pkg::MS_W-1:0]      pr_rdata;
  logic [mtes_pkg::MS_W-1:0]      sat_tmo;

  logic                           in_acc;
  logic                           slot_ok;
  logic [IW-1:0]                  slot_idx;

  assign s_axis_tready = (state_q == mtes_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_vld_q | m_axis_tready;
  assign slot_ok       = ({28'd0, slot_q} < 32'(NUM_TIMERS));
  assign slot_idx      = IW'(slot_q);
  assign sat_tmo       = (|alu_res[DW-1:31]) ? mtes_pkg::TMO_MAX : alu_res[31:0];

  mtes_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .sub_i    (alu_sub),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  mtes_ram #(.Width(DW), .Depth(NUM_TIMERS)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (alu_res),
    .raddr_i (rd_addr),
    .rdata_o (dl_rdata)
  );

  mtes_ram #(.Width(mtes_pkg::MS_W), .Depth(NUM_TIMERS)) u_pr_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (slot_idx),
    .wdata_i (period_q),
    .raddr_i (rd_addr),
    .rdata_o (pr_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    armed_d    = armed_q;
    status_d   = status_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_dl_d  = best_dl_q;
    alu_a      = {1'b0, cur_q};
    alu_b      = '0;
    alu_sub    = 1'b0;
    dl_we      = 1'b0;
    dl_waddr   = slot_idx;
    pr_we      = 1'b0;
    rd_addr    = best_idx_q;
    ld_out     = 1'b0;
    ld_kind    = mtes_pkg::KIND_FINAL;
    ld_status  = status_q;
    ld_fired   = '0;
    ld_tmo     = mtes_pkg::TMO_DUE;

    unique case (state_q)
      mtes_pkg::ST_IDLE: begin
        status_d = mtes_pkg::STATUS_OK;
        if (in_acc) begin
          state_d = mtes_pkg::ST_EXEC;
        end
      end

      // apply the operation, deadline = time + delay
      mtes_pkg::ST_EXEC: begin
        alu_b = DW'(delay_q);
        unique case (op_q)
          mtes_pkg::OP_START: begin
            if (slot_ok) begin
              dl_we             = 1'b1;
              pr_we             = 1'b1;
              armed_d[slot_idx] = 1'b1;
            end
          end
          mtes_pkg::OP_STOP: begin
            if (slot_ok) begin
              armed_d[slot_idx] = 1'b0;
            end
          end
          mtes_pkg::OP_RESET: begin
            if (slot_ok && armed_q[slot_idx]) begin
              dl_we = 1'b1;
            end else begin
              status_d = mtes_pkg::STATUS_UNARMED;
            end
          end
          mtes_pkg::OP_ADV: begin
            cur_d = now_q;
          end
          default: ;
        endcase
        cnt_d      = '0;
        best_vld_d = 1'b0;
        state_d    = mtes_pkg::ST_SCAN;
      end

      // sweep all slots for the earliest armed deadline, lower slot wins ties
      mtes_pkg::ST_SCAN: begin
        rd_addr = cnt_q[IW-1:0];
        if (cnt_q < CW'(NUM_TIMERS)) begin
          cnt_d     = cnt_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IW-1:0];
        end
        alu_a   = dl_rdata;
        alu_b   = best_dl_q;
        alu_sub = 1'b1;
        if (cmp_vld_q && armed_q[cmp_idx_q] && (!best_vld_q || alu_borrow)) begin
          best_vld_d = 1'b1;
          best_idx_d = cmp_idx_q;
          best_dl_d  = dl_rdata;
        end
        if ((cnt_q == CW'(NUM_TIMERS)) && !cmp_vld_q) begin
          state_d = mtes_pkg::ST_CHECK;
        end
      end

      // due check: time - earliest deadline
      mtes_pkg::ST_CHECK: begin
        alu_b   = best_dl_q;
        alu_sub = 1'b1;
        if (!best_vld_q) begin
          ld_tmo = mtes_pkg::TMO_NONE;
          if (out_free) begin
            ld_out  = 1'b1;
            state_d = mtes_pkg::ST_IDLE;
          end
        end else if (!alu_borrow) begin
          if (op_q == mtes_pkg::OP_ADV) begin
            state_d = mtes_pkg::ST_FIRE_RD;
          end else if (out_free) begin
            ld_out  = 1'b1;
            state_d = mtes_pkg::ST_IDLE;
          end
        end else begin
          state_d = mtes_pkg::ST_TMO;
        end
      end

      // remaining time, saturated
      mtes_pkg::ST_TMO: begin
        alu_a   = best_dl_q;
        alu_b   = {1'b0, cur_q};
        alu_sub = 1'b1;
        ld_tmo  = sat_tmo;
        if (out_free) begin
          ld_out  = 1'b1;
          state_d = mtes_pkg::ST_IDLE;
        end
      end

      // fetch the period of the expiring slot
      mtes_pkg::ST_FIRE_RD: begin
        state_d = mtes_pkg::ST_FIRE_UPD;
      end

      // report the slot, then reload or disarm it and rescan
      mtes_pkg::ST_FIRE_UPD: begin
        alu_b     = DW'(pr_rdata);
        dl_waddr  = best_idx_q;
        ld_kind   = mtes_pkg::KIND_REPORT;
        ld_status = mtes_pkg::STATUS_OK;
        ld_fired  = mtes_pkg::SLOT_W'(best_idx_q);
        if (out_free) begin
          ld_out = 1'b1;
          if (pr_rdata != '0) begin
            dl_we = 1'b1;
          end else begin
            armed_d[best_idx_q] = 1'b0;
          end
          cnt_d      = '0;
          best_vld_d = 1'b0;
          state_d    = mtes_pkg::ST_SCAN;
        end
      end

      default: begin
        state_d = mtes_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mtes_pkg::ST_IDLE;
      cur_q      <= '0;
      armed_q    <= '0;
      status_q   <= mtes_pkg::STATUS_OK;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      armed_q    <= armed_d;
      status_q   <= status_d;
      cnt_q      <= cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      best_vld_q <= best_vld_d;
      if (ld_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= mtes_pkg::op_e'(s_axis_tdata[1:0]);
      slot_q   <= s_axis_tdata[5:2];
      delay_q  <= s_axis_tdata[37:6];
      period_q <= s_axis_tdata[69:38];
      now_q    <= s_axis_tdata[117:70];
    end
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_dl_q  <= best_dl_d;
    if (ld_out) begin
      kind_q       <= ld_kind;
      fired_q      <= ld_fired;
      status_out_q <= ld_status;
      tmo_q        <= ld_tmo;
      last_q       <= ld_kind;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = {3'b000, tmo_q, status_out_q, fired_q};
  assign m_axis_tuser[0] = kind_q;
  assign m_axis_tlast    = last_q;

endmodule

[hw/rtl/mtes_checker.sv]
// port level checks of the multi timer expiry scheduler
// depends on mtes_pkg; bound to multi_timer_expiry_scheduler_unit below
module mtes_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [mtes_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // only the final word closes an operation
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
    else $error("tlast and kind disagree");

  // expiry reports carry zero status and timeout
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[39:4] == 36'd0))
    else $error("expiry report carries status or timeout");

  // final timeout is either none or non-negative
  a_tmo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast
      |-> (m_axis_tdata[36] == 1'b0) || (m_axis_tdata[36:5] == mtes_pkg::TMO_NONE))
    else $error("final timeout out of range");

  // no new word is taken while an expiry report is still on the output
  a_busy_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input accepted in the middle of an expiry run");

endmodule

bind multi_timer_expiry_scheduler_unit mtes_checker u_mtes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

[test/tb_multi_timer_expiry_scheduler_unit.sv]
// testbench for multi_timer_expiry_scheduler_unit: directed table then random timer traffic,
// every output word checked against a behavioral timer queue kept inside the bench
// depends on mtes_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb_multi_timer_expiry_scheduler_unit;
  import mtes_pkg::*;

  localparam int NUM_TIMERS = 16;

  // one output word, fields as the block reports them
  typedef struct packed {
    logic            kind;
    logic [3:0]      fired;
    logic            status;
    logic [MS_W-1:0] tmo;
    logic            last;
  } timer_word_t;

  // one stimulus row; typed rows carry the final word read off by hand
  typedef struct {
    op_e               op;
    logic [3:0]        slot;
    logic [MS_W-1:0]   delay;
    logic [MS_W-1:0]   period;
    logic [TIME_W-1:0] now;
    logic              typed;
    logic              status;
    logic [MS_W-1:0]   tmo;
  } timer_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  // shadow copy of the timer queue
  logic [TIME_W-1:0] shadow_time;
  logic              shadow_armed    [NUM_TIMERS];
  logic [DL_W-1:0]   shadow_deadline [NUM_TIMERS];
  logic [MS_W-1:0]   shadow_period   [NUM_TIMERS];

  timer_word_t timer_words_q[$];
  timer_cmd_t  directed_cmds[$];
  int          mismatch_count = 0;
  int          cmds_sent = 0;
  int          random_sent = 0;
  logic        calm = 1'b0;

  multi_timer_expiry_scheduler_unit #(
    .NUM_TIMERS(NUM_TIMERS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // armed slot with the smallest deadline, lowest slot on ties, -1 if none
  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (shadow_armed[i] && (best < 0 || shadow_deadline[i] < shadow_deadline[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // apply one operation to the shadow queue and store the words it must produce
  task automatic predict_timer_words(input timer_cmd_t c);
    int          e;
    logic        stat;
    logic [48:0] diff;
    timer_word_t w;
    stat = STATUS_OK;
    case (c.op)
      OP_START: begin
        shadow_deadline[c.slot] = {1'b0, shadow_time} + DL_W'(c.delay);
        shadow_period[c.slot]   = c.period;
        shadow_armed[c.slot]    = 1'b1;
      end
      OP_STOP: begin
        shadow_armed[c.slot] = 1'b0;
      end
      OP_RESET: begin
        if (shadow_armed[c.slot]) begin
          shadow_deadline[c.slot] = {1'b0, shadow_time} + DL_W'(c.delay);
        end else begin
          stat = STATUS_UNARMED;
        end
      end
      default: begin
        shadow_time = c.now;
        e = earliest_armed();
        // expire due slots in deadline order
        while (e >= 0 && shadow_deadline[e] <= {1'b0, shadow_time}) begin
          if (shadow_period[e] != '0) begin
            shadow_deadline[e] = {1'b0, shadow_time} + DL_W'(shadow_period[e]);
          end else begin
            shadow_armed[e] = 1'b0;
          end
          w = '{KIND_REPORT, 4'(e), STATUS_OK, '0, 1'b0};
          timer_words_q.push_back(w);
          e = earliest_armed();
        end
      end
    endcase
    // final word with the next timeout
    e = earliest_armed();
    w = '{KIND_FINAL, 4'd0, stat, TMO_NONE, 1'b1};
    if (e >= 0) begin
      if (shadow_deadline[e] <= {1'b0, shadow_time}) begin
        w.tmo = TMO_DUE;
      end else begin
        diff  = shadow_deadline[e] - {1'b0, shadow_time};
        w.tmo = (diff > 49'(TMO_MAX)) ? TMO_MAX : diff[MS_W-1:0];
      end
    end
    if (c.typed) begin
      w.status = c.status;
      w.tmo    = c.tmo;
    end
    timer_words_q.push_back(w);
  endtask

  // offer one word on the input side, predict once it is taken
  task automatic send_cmd(input timer_cmd_t c);
    while (!calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b00, c.now, c.period, c.delay, c.slot, c.op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_timer_words(c);
    cmds_sent++;
    calm = (cmds_sent >= 120 && cmds_sent < 200);
  endtask

  // delays and periods: mostly short, sometimes any 32-bit value
  function automatic logic [MS_W-1:0] pick_ms(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    if (r < 75) return MS_W'($urandom_range(1, 200));
    if (r < 88) return MS_W'($urandom_range(0, 100000));
    return $urandom();
  endfunction

  // a new time for advance: mostly forward in small steps
  function automatic logic [TIME_W-1:0] pick_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return shadow_time + TIME_W'($urandom_range(0, 150));
    if (r < 85) return shadow_time + TIME_W'($urandom_range(0, 1 << 20));
    if (r < 92) return shadow_time - TIME_W'($urandom_range(0, 100));
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int         r;
    r = $urandom_range(0, 99);
    c.op     = (r < 35) ? OP_START : (r < 45) ? OP_STOP : (r < 60) ? OP_RESET : OP_ADV;
    c.slot   = 4'($urandom_range(0, NUM_TIMERS - 1));
    c.delay  = pick_ms(5);
    c.period = pick_ms(30);
    c.now    = (c.op == OP_ADV) ? pick_now() : {16'($urandom()), 32'($urandom())};
    c.typed  = 1'b0;
    c.status = STATUS_OK;
    c.tmo    = '0;
    return c;
  endfunction

  // output side: random backpressure and checking
  initial begin
    timer_word_t got;
    timer_word_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[36:5],
                m_axis_tlast};
        if (timer_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected word kind=%0d slot=%0d status=%0d tmo=%0d last=%0d",
                     $realtime, got.kind, got.fired, got.status, $signed(got.tmo), got.last);
          end
        end else begin
          want = timer_words_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected kind=%0d slot=%0d status=%0d tmo=%0d last=%0d",
                       $realtime, want.kind, want.fired, want.status, $signed(want.tmo),
                       want.last);
              $display("%0t:      got kind=%0d slot=%0d status=%0d tmo=%0d last=%0d",
                       $realtime, got.kind, got.fired, got.status, $signed(got.tmo),
                       got.last);
            end
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // reset, directed table, random traffic, drain
  initial begin
    timer_cmd_t c;
    shadow_time = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      shadow_armed[i]    = 1'b0;
      shadow_deadline[i] = '0;
      shadow_period[i]   = '0;
    end

    // op, slot, delay, period, now, typed, status, timeout
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_NONE});
    directed_cmds.push_back('{OP_RESET, 4'd3,  32'd5,  32'd0, 48'd0, 1'b1, STATUS_UNARMED,
                              TMO_NONE});
    directed_cmds.push_back('{OP_STOP,  4'd3,  32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_NONE});
    // zero delay is due at once
    directed_cmds.push_back('{OP_START, 4'd0,  32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_DUE});
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd0, 1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0, 1'b1,
                              STATUS_OK, TMO_MAX});
    directed_cmds.push_back('{OP_START, 4'd1,  32'd10, 32'd10, 48'd0, 1'b1, STATUS_OK, 32'd10});
    directed_cmds.push_back('{OP_START, 4'd2,  32'd10, 32'd0,  48'd0, 1'b1, STATUS_OK, 32'd10});
    directed_cmds.push_back('{OP_RESET, 4'd1,  32'd10, 32'd0,  48'd0, 1'b1, STATUS_OK, 32'd10});
    // tie on deadline, lower slot first
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd10, 1'b0, STATUS_OK, '0});
    // time going backwards
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd5,  1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_RESET, 4'd1,  32'd0,  32'd0, 48'd0,  1'b1, STATUS_OK, TMO_DUE});
    // largest time, reloaded deadlines go past 48 bits
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'hFFFF_FFFF_FFFF, 1'b0,
                              STATUS_OK, '0});
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'hFFFF_FFFF_FFFF, 1'b0,
                              STATUS_OK, '0});
    directed_cmds.push_back('{OP_STOP,  4'd1,  32'd0,  32'd0, 48'd0, 1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_STOP,  4'd15, 32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_NONE});
    // timeout saturation on both sides of the limit
    directed_cmds.push_back('{OP_START, 4'd7,  32'h8000_0000, 32'd1, 48'd0, 1'b1,
                              STATUS_OK, TMO_MAX});
    directed_cmds.push_back('{OP_START, 4'd8,  32'h7FFF_FFFF, 32'd0, 48'd0, 1'b1,
                              STATUS_OK, TMO_MAX});
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd0, 1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_STOP,  4'd7,  32'd0,  32'd0, 48'd0, 1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_STOP,  4'd8,  32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_NONE});
    directed_cmds.push_back('{OP_START, 4'd5,  32'd3,  32'h8000_0000, 48'd0, 1'b1,
                              STATUS_OK, 32'd3});
    directed_cmds.push_back('{OP_RESET, 4'd9,  32'd1,  32'd0, 48'd0, 1'b1, STATUS_UNARMED,
                              32'd3});
    directed_cmds.push_back('{OP_ADV,   4'd0,  32'd0,  32'd0, 48'd3, 1'b0, STATUS_OK, '0});
    directed_cmds.push_back('{OP_STOP,  4'd5,  32'd0,  32'd0, 48'd0, 1'b1, STATUS_OK, TMO_NONE});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    // random traffic, now and then every slot armed and expired in one advance
    while (random_sent < 350) begin
      if ($urandom_range(0, 99) < 4) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          c        = random_cmd();
          c.op     = OP_START;
          c.slot   = 4'(i);
          c.delay  = MS_W'($urandom_range(0, 3));
          c.period = ($urandom_range(0, 1) == 0) ? '0 : MS_W'($urandom_range(1, 50));
          send_cmd(c);
        end
        c     = random_cmd();
        c.op  = OP_ADV;
        c.now = shadow_time + TIME_W'(3);
        send_cmd(c);
        random_sent += NUM_TIMERS + 1;
      end else begin
        send_cmd(random_cmd());
        random_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain and let the sequencer settle
    while (timer_words_q.size() != 0) @(posedge clk_i);
    repeat (4 * (NUM_TIMERS + 4)) @(posedge clk_i);

    if (mismatch_count == 0 && timer_words_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
